>>> design/qrs_pkg.sv
// ----------------------------------------------------------------------------
// qrs_pkg: shared definitions for the quadratic root solver
// Default widths, result width, queue depth and the result kind codes.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;
    localparam int VAL_BITS      = 40;
    localparam int QUEUE_DEPTH   = 4;

    typedef enum logic [1:0] {
        KIND_TWO_REAL   = 2'd0,
        KIND_ONE_REAL   = 2'd1,
        KIND_COMPLEX    = 2'd2,
        KIND_DEGENERATE = 2'd3
    } kind_t;

endpackage

>>> design/quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// quadratic_root_solver_core: roots of a*x^2 + b*x + c = 0
// Exact discriminant, pipelined square root and division, Q24.16 results.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  input    in_valid, in_ready   coef_a, coef_b, coef_c (signed Q8.8)
//  output   out_valid, out_ready root_kind, first_value, second_value (Q24.16)
//
//  One item is accepted per cycle unless the front stage is held by a full queue;
//  each result passes the front stage, the queue, the square root and divider
//  pipelines, which resolve one bit per stage, and the output register.
//  Reset clears all valid flags and the queue; no clearing pass is needed.
//  A stalled output freezes the back pipeline; the front stage and queue keep
//  accepting items until the queue is full.
// ----------------------------------------------------------------------------
module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int COEF_BITS = COEF_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic signed [COEF_BITS-1:0] coef_a,
    input  logic signed [COEF_BITS-1:0] coef_b,
    input  logic signed [COEF_BITS-1:0] coef_c,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  root_kind,
    output logic signed [VAL_BITS-1:0]  first_value,
    output logic signed [VAL_BITS-1:0]  second_value
);

    localparam int CB  = COEF_BITS;
    localparam int DW  = 2 * CB + 3;
    localparam int MW  = 2 * CB + 1;
    localparam int RW  = (MW + 1) / 2 + FRAC_BITS;
    localparam int SW  = 2 + 2 * CB;
    localparam int QEW = 2 + 2 * CB + DW;
    localparam int QW  = CB + FRAC_BITS + 2;
    localparam int EW  = ((QW + 1 > VAL_BITS) ? QW + 1 : VAL_BITS) + 1;

    logic                 push;
    logic                 push_ready;
    kind_t                push_kind;
    logic signed [CB-1:0] push_a;
    logic signed [CB-1:0] push_b;
    logic signed [DW-1:0] push_d;

    logic                 q_full;
    logic                 q_empty;
    logic                 q_pop;
    logic [QEW-1:0]       q_data;
    kind_t                q_kind;
    logic signed [CB-1:0] q_a;
    logic signed [CB-1:0] q_b;
    logic signed [DW-1:0] q_d;
    logic [MW-1:0]        q_mag;

    logic                 adv;
    logic                 s_valid;
    logic [RW-1:0]        s_root;
    logic [SW-1:0]        s_side;
    kind_t                s_kind;
    logic signed [CB-1:0] s_a;
    logic signed [CB-1:0] s_b;

    logic                 d_valid;
    kind_t                d_kind;
    logic [QW-1:0]        d_q1;
    logic [QW-1:0]        d_q2;
    logic                 d_neg1;
    logic                 d_neg2;

    logic signed [EW-1:0] v1_ext;
    logic signed [EW-1:0] v2_ext;
    logic signed [EW-1:0] sat_hi;
    logic signed [EW-1:0] sat_lo;
    logic signed [VAL_BITS-1:0] v1_sat;
    logic signed [VAL_BITS-1:0] v2_sat;

    logic                       o_valid_reg;
    logic                       o_valid_next;
    kind_t                      o_kind_reg;
    logic signed [VAL_BITS-1:0] o_first_reg;
    logic signed [VAL_BITS-1:0] o_second_reg;

    qrs_front #(.CB(CB)) u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .coef_a     (coef_a),
        .coef_b     (coef_b),
        .coef_c     (coef_c),
        .push       (push),
        .push_ready (push_ready),
        .push_kind  (push_kind),
        .push_a     (push_a),
        .push_b     (push_b),
        .push_d     (push_d)
    );

    assign push_ready = !q_full;

    qrs_queue #(.W(QEW), .DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data ({push_kind, push_a, push_b, push_d}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    assign adv   = !o_valid_reg || out_ready;
    assign q_pop = adv && !q_empty;

    assign q_kind = kind_t'(q_data[QEW-1 -: 2]);
    assign q_a    = q_data[QEW-3 -: CB];
    assign q_b    = q_data[QEW-3-CB -: CB];
    assign q_d    = q_data[DW-1:0];
    assign q_mag  = q_d[DW-1] ? MW'(-q_d) : MW'(q_d);

    qrs_sqrt #(.MW(MW), .FB(FRAC_BITS), .SW(SW)) u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (q_pop),
        .in_mag    (q_mag),
        .in_side   ({q_kind, q_a, q_b}),
        .out_valid (s_valid),
        .out_root  (s_root),
        .out_side  (s_side)
    );

    assign s_kind = kind_t'(s_side[SW-1 -: 2]);
    assign s_a    = s_side[SW-3 -: CB];
    assign s_b    = s_side[CB-1:0];

    qrs_div #(.CB(CB), .FB(FRAC_BITS), .RW(RW)) u_div
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_kind   (s_kind),
        .in_a      (s_a),
        .in_b      (s_b),
        .in_root   (s_root),
        .out_valid (d_valid),
        .out_kind  (d_kind),
        .out_q1    (d_q1),
        .out_q2    (d_q2),
        .out_neg1  (d_neg1),
        .out_neg2  (d_neg2)
    );

    assign sat_hi = {{(EW - VAL_BITS + 1){1'b0}}, {(VAL_BITS - 1){1'b1}}};
    assign sat_lo = {{(EW - VAL_BITS + 1){1'b1}}, {(VAL_BITS - 1){1'b0}}};
    assign v1_ext = d_neg1 ? -signed'(EW'(d_q1)) : signed'(EW'(d_q1));
    assign v2_ext = d_neg2 ? -signed'(EW'(d_q2)) : signed'(EW'(d_q2));

    always_comb
    begin
        if (v1_ext > sat_hi)
        begin
            v1_sat = sat_hi[VAL_BITS-1:0];
        end
        else if (v1_ext < sat_lo)
        begin
            v1_sat = sat_lo[VAL_BITS-1:0];
        end
        else
        begin
            v1_sat = v1_ext[VAL_BITS-1:0];
        end
        if (v2_ext > sat_hi)
        begin
            v2_sat = sat_hi[VAL_BITS-1:0];
        end
        else if (v2_ext < sat_lo)
        begin
            v2_sat = sat_lo[VAL_BITS-1:0];
        end
        else
        begin
            v2_sat = v2_ext[VAL_BITS-1:0];
        end
    end

    assign o_valid_next = adv ? d_valid : o_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o_valid_reg <= 1'b0;
        end
        else
        begin
            o_valid_reg <= o_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            o_kind_reg <= d_kind;
            if (d_kind == KIND_DEGENERATE)
            begin
                o_first_reg  <= '0;
                o_second_reg <= '0;
            end
            else
            begin
                o_first_reg  <= v1_sat;
                o_second_reg <= v2_sat;
            end
        end
    end

    assign out_valid    = o_valid_reg;
    assign root_kind    = o_kind_reg;
    assign first_value  = o_first_reg;
    assign second_value = o_second_reg;

    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && (o_kind_reg == KIND_DEGENERATE) |->
            (o_first_reg == '0) && (o_second_reg == '0))
        else $error("degenerate result carries nonzero values");

    a_one_real_equal: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && (o_kind_reg == KIND_ONE_REAL) |-> (o_first_reg == o_second_reg))
        else $error("repeated root differs between fields");

    a_pop_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_stall_holds_back: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && !out_ready |=> $stable(d_valid) && (!d_valid || $stable(d_q1)))
        else $error("back pipeline moved while output stalled");

endmodule

>>> design/qrs_front.sv
// ----------------------------------------------------------------------------
// qrs_front: input stage of the quadratic root solver
// Registers the products b*b and a*c, then forms the discriminant and its kind.
// ----------------------------------------------------------------------------
module qrs_front
    import qrs_pkg::*;
#(
    parameter int CB = COEF_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [CB-1:0]   coef_a,
    input  logic signed [CB-1:0]   coef_b,
    input  logic signed [CB-1:0]   coef_c,
    output logic                   push,
    input  logic                   push_ready,
    output kind_t                  push_kind,
    output logic signed [CB-1:0]   push_a,
    output logic signed [CB-1:0]   push_b,
    output logic signed [2*CB+2:0] push_d
);

    localparam int DW = 2 * CB + 3;

    logic                   p_valid_reg;
    logic                   p_valid_next;
    logic signed [CB-1:0]   a_reg;
    logic signed [CB-1:0]   b_reg;
    logic signed [2*CB-1:0] bb_reg;
    logic signed [2*CB-1:0] ac_reg;
    logic                   in_fire;

    assign in_ready = !p_valid_reg || push_ready;
    assign in_fire  = in_valid && in_ready;
    assign push     = p_valid_reg;

    always_comb
    begin
        if (in_fire)
        begin
            p_valid_next = 1'b1;
        end
        else if (push_ready)
        begin
            p_valid_next = 1'b0;
        end
        else
        begin
            p_valid_next = p_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg <= p_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            a_reg  <= coef_a;
            b_reg  <= coef_b;
            bb_reg <= coef_b * coef_b;
            ac_reg <= coef_a * coef_c;
        end
    end

    assign push_d = DW'(bb_reg) - (DW'(ac_reg) <<< 2);
    assign push_a = a_reg;
    assign push_b = b_reg;

    always_comb
    begin
        if (a_reg == '0)
        begin
            push_kind = KIND_DEGENERATE;
        end
        else if (push_d == '0)
        begin
            push_kind = KIND_ONE_REAL;
        end
        else if (push_d[DW-1])
        begin
            push_kind = KIND_COMPLEX;
        end
        else
        begin
            push_kind = KIND_TWO_REAL;
        end
    end

endmodule

>>> design/qrs_queue.sv
// ----------------------------------------------------------------------------
// qrs_queue: short first-in first-out queue
// Decouples the classifying front stage from the arithmetic pipeline.
// ----------------------------------------------------------------------------
module qrs_queue
    import qrs_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] pop_data,
    output logic         empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic          do_push;
    logic          do_pop;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/qrs_sqrt.sv
// ----------------------------------------------------------------------------
// qrs_sqrt: pipelined digit-by-digit square root
// One result bit per stage gives floor(sqrt(mag) * 2^FB); side data rides along.
// ----------------------------------------------------------------------------
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int MW = 2 * COEF_BITS_DEF + 1,
    parameter int FB = FRAC_BITS_DEF,
    parameter int SW = 2 * COEF_BITS_DEF + 2
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       adv,
    input  logic                       in_valid,
    input  logic [MW-1:0]              in_mag,
    input  logic [SW-1:0]              in_side,
    output logic                       out_valid,
    output logic [(MW+1)/2+FB-1:0]     out_root,
    output logic [SW-1:0]              out_side
);

    localparam int NP  = (MW + 1) / 2;
    localparam int NS  = NP + FB;
    localparam int RW  = NS;
    localparam int RMW = RW + 3;
    localparam int BW  = 2 * NS;

    logic           v_reg    [NS];
    logic [RMW-1:0] rem_reg  [NS];
    logic [RW-1:0]  root_reg [NS];
    logic [BW-1:0]  mb_reg   [NS];
    logic [SW-1:0]  side_reg [NS];

    logic [2*NP-1:0] mag_pad;
    logic [BW-1:0]   mb_first;

    assign mag_pad  = (2 * NP)'(in_mag);
    assign mb_first = {mag_pad, {(2 * FB){1'b0}}};

    for (genvar i = 0; i < NS; i++)
    begin : g_stage
        logic           v_in;
        logic [RMW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [BW-1:0]  mb_in;
        logic [SW-1:0]  side_in;
        logic [RMW-1:0] rem_sh;
        logic [RMW-1:0] trial;
        logic           ge;

        if (i == 0)
        begin : g_head
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign mb_in   = mb_first;
            assign side_in = in_side;
        end
        else
        begin : g_body
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign mb_in   = mb_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        assign rem_sh = {rem_in[RMW-3:0], mb_in[BW-1 -: 2]};
        assign trial  = RMW'({root_in, 2'b01});
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[i]  <= ge ? rem_sh - trial : rem_sh;
                root_reg[i] <= {root_in[RW-2:0], ge};
                mb_reg[i]   <= {mb_in[BW-3:0], 2'b00};
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[NS-1];
    assign out_root  = root_reg[NS-1];
    assign out_side  = side_reg[NS-1];

endmodule

>>> design/qrs_div.sv
// ----------------------------------------------------------------------------
// qrs_div: numerator selection and two pipelined restoring dividers
// Divides both numerators by 2a on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qrs_div
    import qrs_pkg::*;
#(
    parameter int CB = COEF_BITS_DEF,
    parameter int FB = FRAC_BITS_DEF,
    parameter int RW = COEF_BITS_DEF + 1 + FRAC_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  logic                 in_valid,
    input  kind_t                in_kind,
    input  logic signed [CB-1:0] in_a,
    input  logic signed [CB-1:0] in_b,
    input  logic [RW-1:0]        in_root,
    output logic                 out_valid,
    output kind_t                out_kind,
    output logic [CB+FB+1:0]     out_q1,
    output logic [CB+FB+1:0]     out_q2,
    output logic                 out_neg1,
    output logic                 out_neg2
);

    localparam int NW   = CB + FB + 3;
    localparam int QW   = NW - 1;
    localparam int DENW = CB + 1;

    logic signed [NW-1:0] nb;
    logic signed [NW-1:0] sx;
    logic signed [NW-1:0] n1;
    logic signed [NW-1:0] n2;
    logic [DENW-1:0]      den2;
    logic                 den_neg;

    logic            f_valid_reg;
    kind_t           f_kind_reg;
    logic [QW-1:0]   f_n1_reg;
    logic [QW-1:0]   f_n2_reg;
    logic            f_neg1_reg;
    logic            f_neg2_reg;
    logic [DENW-1:0] f_den_reg;

    logic            v_reg    [QW];
    kind_t           kind_reg [QW];
    logic [QW-1:0]   nq1_reg  [QW];
    logic [QW-1:0]   nq2_reg  [QW];
    logic [DENW-1:0] r1_reg   [QW];
    logic [DENW-1:0] r2_reg   [QW];
    logic            neg1_reg [QW];
    logic            neg2_reg [QW];
    logic [DENW-1:0] den_reg  [QW];

    assign nb      = (-(NW'(in_b))) <<< FB;
    assign sx      = signed'(NW'(in_root));
    assign den2    = {in_a, 1'b0};
    assign den_neg = in_a[CB-1];

    always_comb
    begin
        case (in_kind)
            KIND_TWO_REAL:
            begin
                n1 = nb + sx;
                n2 = nb - sx;
            end
            KIND_ONE_REAL:
            begin
                n1 = nb;
                n2 = nb;
            end
            KIND_COMPLEX:
            begin
                n1 = nb;
                n2 = sx;
            end
            default:
            begin
                n1 = '0;
                n2 = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            f_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f_kind_reg <= in_kind;
            f_n1_reg   <= n1[NW-1] ? QW'(-n1) : QW'(n1);
            f_n2_reg   <= n2[NW-1] ? QW'(-n2) : QW'(n2);
            f_neg1_reg <= n1[NW-1] ^ den_neg;
            f_neg2_reg <= n2[NW-1] ^ den_neg;
            f_den_reg  <= den_neg ? (~den2 + 1'b1) : den2;
        end
    end

    for (genvar i = 0; i < QW; i++)
    begin : g_stage
        logic            v_in;
        kind_t           kind_in;
        logic [QW-1:0]   nq1_in;
        logic [QW-1:0]   nq2_in;
        logic [DENW-1:0] r1_in;
        logic [DENW-1:0] r2_in;
        logic            neg1_in;
        logic            neg2_in;
        logic [DENW-1:0] den_in;
        logic [DENW:0]   rs1;
        logic [DENW:0]   rs2;
        logic            ge1;
        logic            ge2;

        if (i == 0)
        begin : g_head
            assign v_in    = f_valid_reg;
            assign kind_in = f_kind_reg;
            assign nq1_in  = f_n1_reg;
            assign nq2_in  = f_n2_reg;
            assign r1_in   = '0;
            assign r2_in   = '0;
            assign neg1_in = f_neg1_reg;
            assign neg2_in = f_neg2_reg;
            assign den_in  = f_den_reg;
        end
        else
        begin : g_body
            assign v_in    = v_reg[i-1];
            assign kind_in = kind_reg[i-1];
            assign nq1_in  = nq1_reg[i-1];
            assign nq2_in  = nq2_reg[i-1];
            assign r1_in   = r1_reg[i-1];
            assign r2_in   = r2_reg[i-1];
            assign neg1_in = neg1_reg[i-1];
            assign neg2_in = neg2_reg[i-1];
            assign den_in  = den_reg[i-1];
        end

        assign rs1 = {r1_in, nq1_in[QW-1]};
        assign rs2 = {r2_in, nq2_in[QW-1]};
        assign ge1 = (rs1 >= {1'b0, den_in});
        assign ge2 = (rs2 >= {1'b0, den_in});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                kind_reg[i] <= kind_in;
                nq1_reg[i]  <= {nq1_in[QW-2:0], ge1};
                nq2_reg[i]  <= {nq2_in[QW-2:0], ge2};
                r1_reg[i]   <= ge1 ? DENW'(rs1 - {1'b0, den_in}) : DENW'(rs1);
                r2_reg[i]   <= ge2 ? DENW'(rs2 - {1'b0, den_in}) : DENW'(rs2);
                neg1_reg[i] <= neg1_in;
                neg2_reg[i] <= neg2_in;
                den_reg[i]  <= den_in;
            end
        end
    end

    assign out_valid = v_reg[QW-1];
    assign out_kind  = kind_reg[QW-1];
    assign out_q1    = nq1_reg[QW-1];
    assign out_q2    = nq2_reg[QW-1];
    assign out_neg1  = neg1_reg[QW-1];
    assign out_neg2  = neg2_reg[QW-1];

endmodule

>>> tb/tb_quadratic_root_solver_core.sv
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver_core: self-checking bench for the root solver
// Drives directed and random coefficient sets through the valid/ready input,
// predicts each result by a fixed-point solver or from a directed set, and
// compares every output item in order, under random idling and back pressure.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver_core;
    import qrs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = COEF_BITS_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int RANDOM_SETS = 1500;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [VAL_BITS-1:0] first;
        logic signed [VAL_BITS-1:0] second;
    } roots_t;

    typedef struct {
        logic signed [CB-1:0] a;
        logic signed [CB-1:0] b;
        logic signed [CB-1:0] c;
        bit                   typed;
        roots_t               want;
    } coef_row_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        in_valid = 1'b0;
    logic                        in_ready;
    logic signed [CB-1:0]        coef_a = '0;
    logic signed [CB-1:0]        coef_b = '0;
    logic signed [CB-1:0]        coef_c = '0;
    logic                        out_valid;
    logic                        out_ready = 1'b0;
    logic [1:0]                  root_kind;
    logic signed [VAL_BITS-1:0]  first_value;
    logic signed [VAL_BITS-1:0]  second_value;

    roots_t    pending_roots[$];
    coef_row_t sets[$];
    int        errors = 0;
    int        roots_seen = 0;
    int        kind_count[4] = '{0, 0, 0, 0};
    bit        quiet_phase = 1'b0;
    bit        hold_drain = 1'b0;
    bit        sender_done = 1'b0;

    always #1 clk = ~clk;

    quadratic_root_solver_core uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
        .out_valid(out_valid), .out_ready(out_ready),
        .root_kind(root_kind), .first_value(first_value), .second_value(second_value)
    );

    function automatic logic [63:0] scaled_root(input logic [63:0] m);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] pair;
        logic [63:0] trial;
        rem = 0;
        root = 0;
        for (int i = 31 + FB; i >= 0; i--) begin
            pair = (i >= FB) ? ((m >> (2 * (i - FB))) & 64'd3) : 64'd0;
            rem = (rem << 2) | pair;
            trial = (root << 2) | 64'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 64'd1;
            end
            else begin
                root = root << 1;
            end
        end
        return root;
    endfunction

    function automatic logic signed [VAL_BITS-1:0] clamp_q(input longint v);
        longint hi;
        hi = (longint'(1) <<< (VAL_BITS - 1)) - 1;
        if (v > hi) v = hi;
        if (v < -hi - 1) v = -hi - 1;
        return v[VAL_BITS-1:0];
    endfunction

    function automatic roots_t solve_roots(input logic signed [CB-1:0] a,
                                           input logic signed [CB-1:0] b,
                                           input logic signed [CB-1:0] c);
        roots_t r;
        longint disc;
        longint s;
        longint den;
        longint nb;
        if (a == 0) begin
            r.kind = KIND_DEGENERATE;
            r.first = '0;
            r.second = '0;
            return r;
        end
        disc = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
        s = longint'(scaled_root(disc < 0 ? -disc : disc));
        den = 2 * longint'(a);
        nb = -longint'(b) * (longint'(1) <<< FB);
        if (disc == 0) begin
            r.kind = KIND_ONE_REAL;
            r.first = clamp_q(nb / den);
            r.second = r.first;
        end
        else if (disc < 0) begin
            r.kind = KIND_COMPLEX;
            r.first = clamp_q(nb / den);
            r.second = clamp_q(s / den);
        end
        else begin
            r.kind = KIND_TWO_REAL;
            r.first = clamp_q((nb + s) / den);
            r.second = clamp_q((nb - s) / den);
        end
        return r;
    endfunction

    function automatic coef_row_t row(input int a, input int b, input int c);
        coef_row_t t;
        t.a = CB'(a);
        t.b = CB'(b);
        t.c = CB'(c);
        t.typed = 1'b0;
        t.want = '0;
        return t;
    endfunction

    function automatic coef_row_t typed_row(input int a, input int b, input int c,
                                            input logic [1:0] k, input longint f,
                                            input longint s);
        coef_row_t t;
        t = row(a, b, c);
        t.typed = 1'b1;
        t.want.kind = k;
        t.want.first = VAL_BITS'(f);
        t.want.second = VAL_BITS'(s);
        return t;
    endfunction

    function automatic logic signed [CB-1:0] random_coef();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            1: return CB'($urandom_range(0, 3) - 2);
            2: return CB'($urandom_range(0, 511) - 256);
            default: return CB'($urandom);
        endcase
    endfunction

    task automatic send_set(input coef_row_t t);
        roots_t r;
        r = t.typed ? t.want : solve_roots(t.a, t.b, t.c);
        in_valid <= 1'b1;
        coef_a <= t.a;
        coef_b <= t.b;
        coef_c <= t.c;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_roots.push_back(r);
        @(negedge clk);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
    endtask

    always @(posedge clk) begin
        roots_t w;
        if (rst_n && out_valid && out_ready) begin
            roots_seen++;
            kind_count[root_kind]++;
            if (pending_roots.size() == 0) begin
                errors++;
                $display("%t: unexpected item kind=%0d first=%0d second=%0d",
                         $realtime, root_kind, first_value, second_value);
            end
            else begin
                w = pending_roots.pop_front();
                if (root_kind !== w.kind) begin
                    errors++;
                    $display("%t: root_kind expected %0d actual %0d",
                             $realtime, w.kind, root_kind);
                end
                if (first_value !== w.first) begin
                    errors++;
                    $display("%t: first_value expected %0d actual %0d",
                             $realtime, w.first, first_value);
                end
                if (second_value !== w.second) begin
                    errors++;
                    $display("%t: second_value expected %0d actual %0d",
                             $realtime, w.second, second_value);
                end
            end
        end
    end

    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_drain) begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_drain = 1'b0;
            end
            else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        sets.push_back(typed_row(0, 0, 0, KIND_DEGENERATE, 0, 0));
        sets.push_back(typed_row(0, -32768, 32767, KIND_DEGENERATE, 0, 0));
        sets.push_back(typed_row(256, 0, 0, KIND_ONE_REAL, 0, 0));
        sets.push_back(typed_row(256, -512, 256, KIND_ONE_REAL, 65536, 65536));
        sets.push_back(typed_row(256, 0, -256, KIND_TWO_REAL, 65536, -65536));
        sets.push_back(typed_row(256, 0, 256, KIND_COMPLEX, 0, 65536));
        sets.push_back(typed_row(-256, 0, 256, KIND_TWO_REAL, -65536, 65536));
        sets.push_back(row(-256, 0, -256));
        sets.push_back(row(32767, 32767, 32767));
        sets.push_back(row(-32768, -32768, -32768));
        sets.push_back(row(-32768, 32767, 32767));
        sets.push_back(row(1, -32768, 32767));
        sets.push_back(row(1, 32767, -32768));
        sets.push_back(row(-1, -32768, -32768));
        sets.push_back(row(32767, 0, 32767));
        sets.push_back(row(-32768, 0, 32767));
        sets.push_back(row(1, 2, 1));
        sets.push_back(row(-1, 1, 3));
        sets.push_back(row(3, -5, 7));
        sets.push_back(row(-21846, 21845, -21846));

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (sets[i]) send_set(sets[i]);

        for (int n = 0; n < RANDOM_SETS; n++) begin
            coef_row_t t;
            logic signed [CB-1:0] r;
            if (n == 400) hold_drain = 1'b1;
            if (n == 800) begin
                in_valid <= 1'b0;
                wait (pending_roots.size() == 0);
                @(negedge clk);
            end
            if (n == RANDOM_SETS - 200) quiet_phase = 1'b1;
            t = row(random_coef(), random_coef(), random_coef());
            if ($urandom_range(0, 5) == 0) begin
                r = CB'(int'($urandom_range(1, 180)) * ($urandom_range(0, 1) ? 1 : -1));
                t.a = CB'(1);
                t.b = CB'(2 * r);
                t.c = CB'(r * r);
                if ($urandom_range(0, 1)) begin
                    t.a = r;
                    t.b = CB'(2 * r);
                    t.c = r;
                end
            end
            send_set(t);
        end
        in_valid <= 1'b0;
        sender_done = 1'b1;

        wait (pending_roots.size() == 0);
        repeat (100) @(posedge clk);

        $display("Checked %0d result items: two-real %0d, one-real %0d, complex %0d,",
                 roots_seen, kind_count[0], kind_count[1], kind_count[2]);
        $display("degenerate %0d, with random idling and a long output stall.",
                 kind_count[3]);
        if (errors == 0 && pending_roots.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end
        else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> quadratic_root_solver_core.f
design/qrs_pkg.sv
design/qrs_front.sv
design/qrs_queue.sv
design/qrs_sqrt.sv
design/qrs_div.sv
design/quadratic_root_solver_core.sv
tb/tb_quadratic_root_solver_core.sv
